// ----- rtl/core/iof_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iof_pkg
// Widths, constants and item types of the inertial-to-orbital frame rotation.
// ----------------------------------------------------------------------------
package iof_pkg;

	localparam int CW       = 32;            // coordinate width
	localparam int UFB      = 30;            // unit vector fraction bits
	localparam int NB       = 30;            // normalized direction bits
	localparam int UW       = UFB + 2;       // unit vector width
	localparam int XW       = 2 * CW + 1;    // cross product width
	localparam int MW       = XW - 1;        // direction magnitude width
	localparam int LW       = $clog2(MW + 1);
	localparam int SQW      = 2 * NB + 2;    // squared length width
	localparam int RW       = SQW + 1;       // square root work width
	localparam int SQ_STEPS = NB + 1;
	localparam int SW       = NB + 1;        // square root width
	localparam int QB       = NB + 1;        // quotient bits
	localparam int DW2      = 2 * UW + 1;    // j x k term width
	localparam int IW       = DW2 - UFB;     // i axis width
	localparam int PW       = IW + CW;       // dot product term width
	localparam int AW       = PW + 2;        // dot sum width
	localparam int TW       = AW - UFB;      // shifted dot width
	localparam int UNIT_LAT = 4 + SQ_STEPS + QB + 1;

	typedef struct packed {
		logic signed [CW-1:0] pos_x;
		logic signed [CW-1:0] pos_y;
		logic signed [CW-1:0] pos_z;
		logic signed [CW-1:0] vel_x;
		logic signed [CW-1:0] vel_y;
		logic signed [CW-1:0] vel_z;
		logic signed [CW-1:0] vec_x;
		logic signed [CW-1:0] vec_y;
		logic signed [CW-1:0] vec_z;
	} in_t;

	typedef struct packed {
		logic signed [CW-1:0] orb_x;
		logic signed [CW-1:0] orb_y;
		logic signed [CW-1:0] orb_z;
		logic                 degenerate;
	} out_t;

endpackage

// ----- rtl/core/iof_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iof_unit
// Pipelined unit vector: block normalize, squared length, square root
// (one bit per stage) and restoring divide (one quotient bit per stage).
// ----------------------------------------------------------------------------
module iof_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_in,
	input  logic signed [iof_pkg::XW-1:0] vin [3],
	output logic                         vld_out,
	output logic                         zero_out,
	output logic signed [iof_pkg::UW-1:0] uvec [3]
);
	import iof_pkg::*;

	// stage a: magnitudes and bit length
	logic [MW-1:0] magc [3];
	logic [LW-1:0] lenc;
	logic [MW-1:0] mag_a [3];
	logic          neg_a [3];
	logic [LW-1:0] len_a;
	logic          v_a;

	always_comb begin
		logic signed [XW-1:0] ab;
		logic [MW-1:0] orv;
		orv = '0;
		for (int c = 0; c < 3; c++) begin
			ab = vin[c] < 0 ? -vin[c] : vin[c];
			magc[c] = ab[MW-1:0];
			orv = orv | ab[MW-1:0];
		end
		lenc = '0;
		for (int i = 0; i < MW; i++) begin
			if (orv[i]) begin
				lenc = LW'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
		end else if (en) begin
			v_a <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				mag_a[c] <= magc[c];
				neg_a[c] <= vin[c] < 0;
			end
			len_a <= lenc;
		end
	end

	// stage b: common shift to NB bits
	logic [NB-1:0] nc [3];
	logic [NB-1:0] n_b [3];
	logic          neg_b [3];
	logic          zero_b;
	logic          v_b;

	always_comb begin
		logic [MW-1:0] t;
		for (int c = 0; c < 3; c++) begin
			if (len_a > LW'(NB)) begin
				t = mag_a[c] >> (len_a - LW'(NB));
			end else begin
				t = mag_a[c] << (LW'(NB) - len_a);
			end
			nc[c] = t[NB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b <= 1'b0;
		end else if (en) begin
			v_b <= v_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_b    <= nc;
			neg_b  <= neg_a;
			zero_b <= len_a == '0;
		end
	end

	// stage c: squares
	logic [2*NB-1:0] sq_c [3];
	logic [NB-1:0]   n_c [3];
	logic            neg_c [3];
	logic            zero_c;
	logic            v_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c <= 1'b0;
		end else if (en) begin
			v_c <= v_b;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				sq_c[c] <= (2*NB)'(n_b[c]) * (2*NB)'(n_b[c]);
			end
			n_c    <= n_b;
			neg_c  <= neg_b;
			zero_c <= zero_b;
		end
	end

	// stage d: squared length, then square root stages
	logic [SQW-1:0] sm [SQ_STEPS];
	logic [RW-1:0]  sr [SQ_STEPS+1];
	logic [NB-1:0]  sn [SQ_STEPS+1][3];
	logic           sneg [SQ_STEPS+1][3];
	logic           sz [SQ_STEPS+1];
	logic           sv [SQ_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv[0] <= 1'b0;
		end else if (en) begin
			sv[0] <= v_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sm[0]   <= SQW'(sq_c[0]) + SQW'(sq_c[1]) + SQW'(sq_c[2]);
			sr[0]   <= '0;
			sn[0]   <= n_c;
			sneg[0] <= neg_c;
			sz[0]   <= zero_c;
		end
	end

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		localparam logic [RW-1:0] BITV = RW'(1) << (2 * (SQ_STEPS - 1 - i));
		logic [RW-1:0] trial;
		logic          take;

		assign trial = sr[i] + BITV;
		assign take  = {1'b0, sm[i]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv[i+1] <= 1'b0;
			end else if (en) begin
				sv[i+1] <= sv[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sr[i+1]   <= take ? (sr[i] >> 1) + BITV : sr[i] >> 1;
				sn[i+1]   <= sn[i];
				sneg[i+1] <= sneg[i];
				sz[i+1]   <= sz[i];
			end
		end

		if (i < SQ_STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					sm[i+1] <= take ? sm[i] - trial[SQW-1:0] : sm[i];
				end
			end
		end
	end

	// divide stages: |n| * 2^NB / s, one quotient bit each
	logic [SW-1:0] dr [QB-1][3];
	logic [QB-1:0] dq [QB][3];
	logic [SW-1:0] ds [QB-1];
	logic          dneg [QB][3];
	logic          dz [QB];
	logic          dv [QB];

	for (genvar t = 0; t < QB; t++) begin : g_div
		logic [SW-1:0] rin [3];
		logic [QB-1:0] qin [3];
		logic          bi [3];
		logic [SW-1:0] sin;
		logic          negin [3];
		logic          zin;
		logic          vin_t;
		logic [SW-1:0] rnx [3];
		logic          qbit [3];

		if (t == 0) begin : g_first
			always_comb begin
				for (int c = 0; c < 3; c++) begin
					rin[c]   = SW'(sn[SQ_STEPS][c] >> 1);
					qin[c]   = '0;
					bi[c]    = sn[SQ_STEPS][c][0];
					negin[c] = sneg[SQ_STEPS][c];
				end
			end
			assign sin   = sr[SQ_STEPS][SW-1:0];
			assign zin   = sz[SQ_STEPS];
			assign vin_t = sv[SQ_STEPS];
		end else begin : g_next
			always_comb begin
				for (int c = 0; c < 3; c++) begin
					rin[c]   = dr[t-1][c];
					qin[c]   = dq[t-1][c];
					bi[c]    = 1'b0;
					negin[c] = dneg[t-1][c];
				end
			end
			assign sin   = ds[t-1];
			assign zin   = dz[t-1];
			assign vin_t = dv[t-1];
		end

		always_comb begin
			logic [SW:0] sh;
			for (int c = 0; c < 3; c++) begin
				sh      = {rin[c], bi[c]};
				qbit[c] = sh >= {1'b0, sin};
				rnx[c]  = qbit[c] ? SW'(sh - {1'b0, sin}) : SW'(sh);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[t] <= 1'b0;
			end else if (en) begin
				dv[t] <= vin_t;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 3; c++) begin
					dq[t][c]   <= {qin[c][QB-2:0], qbit[c]};
					dneg[t][c] <= negin[c];
				end
				dz[t] <= zin;
			end
		end

		if (t < QB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					dr[t] <= rnx;
					ds[t] <= sin;
				end
			end
		end
	end

	// output stage: scale to UFB fraction bits and apply sign
	logic [UW-1:0] um [3];

	for (genvar c = 0; c < 3; c++) begin : g_scale
		if (UFB >= NB) begin : g_up
			assign um[c] = UW'(dq[QB-1][c]) << (UFB - NB);
		end else begin : g_dn
			assign um[c] = UW'(dq[QB-1][c] >> (NB - UFB));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= dv[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				uvec[c] <= dneg[QB-1][c] ? -$signed(um[c]) : $signed(um[c]);
			end
			zero_out <= dz[QB-1];
		end
	end

endmodule

// ----- rtl/core/inertial_to_orbital_frame_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inertial_to_orbital_frame_top
// Rotates a vector from the inertial frame into the orbital frame built
// from position and velocity (k radial, j orbit normal, i = j x k).
// ----------------------------------------------------------------------------
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+----------------------
//  input    | item_valid   | item_ready   | item   (r, v, u)
//  output   | result_valid | result_ready | result (orb, degenerate)
//
//  One item per cycle while the pipeline is not stalled.
//  Reset clears the valid bits only.
//  A held result stalls the whole pipeline; item_ready drops while it waits.
// ----------------------------------------------------------------------------
module inertial_to_orbital_frame_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  iof_pkg::in_t   item,
	output logic           result_valid,
	input  logic           result_ready,
	output iof_pkg::out_t  result
);
	import iof_pkg::*;

	logic en;
	logic k_v, k_z, j_v, j_z;
	logic v_s1, v_s2, v_s3, v_t1, v_t2, v_t3, v_t4, v_t5, v_t6, v_t7;

	assign en         = !v_t7 || result_ready;
	assign item_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_t1 <= 1'b0;
			v_t2 <= 1'b0;
			v_t3 <= 1'b0;
			v_t4 <= 1'b0;
			v_t5 <= 1'b0;
			v_t6 <= 1'b0;
			v_t7 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_t1 <= k_v && j_v;
			v_t2 <= v_t1;
			v_t3 <= v_t2;
			v_t4 <= v_t3;
			v_t5 <= v_t4;
			v_t6 <= v_t5;
			v_t7 <= v_t6;
		end
	end

	// front: r x v
	in_t                  it_s1;
	logic signed [CW-1:0] r_s2 [3];
	logic signed [CW-1:0] u_s2 [3];
	logic signed [2*CW-1:0] p_s2 [6];
	logic signed [XW-1:0] rr_s3 [3];
	logic signed [XW-1:0] cr_s3 [3];
	logic signed [CW-1:0] u_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= item;

			p_s2[0] <= it_s1.pos_y * it_s1.vel_z;
			p_s2[1] <= it_s1.pos_z * it_s1.vel_y;
			p_s2[2] <= it_s1.pos_z * it_s1.vel_x;
			p_s2[3] <= it_s1.pos_x * it_s1.vel_z;
			p_s2[4] <= it_s1.pos_x * it_s1.vel_y;
			p_s2[5] <= it_s1.pos_y * it_s1.vel_x;
			r_s2    <= '{it_s1.pos_x, it_s1.pos_y, it_s1.pos_z};
			u_s2    <= '{it_s1.vec_x, it_s1.vec_y, it_s1.vec_z};

			for (int c = 0; c < 3; c++) begin
				cr_s3[c] <= XW'(p_s2[2*c]) - XW'(p_s2[2*c+1]);
				rr_s3[c] <= XW'(r_s2[c]);
			end
			u_s3 <= u_s2;
		end
	end

	// unit vectors
	logic signed [UW-1:0] kk [3];
	logic signed [UW-1:0] jj [3];

	iof_unit u_k (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (v_s3),
		.vin      (rr_s3),
		.vld_out  (k_v),
		.zero_out (k_z),
		.uvec     (kk)
	);

	iof_unit u_j (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (v_s3),
		.vin      (cr_s3),
		.vld_out  (j_v),
		.zero_out (j_z),
		.uvec     (jj)
	);

	// u waits for the unit pipelines and the i axis
	logic signed [CW-1:0] ud_q [UNIT_LAT+3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			ud_q[0] <= u_s3;
			for (int d = 1; d < UNIT_LAT + 3; d++) begin
				ud_q[d] <= ud_q[d-1];
			end
		end
	end

	// i = j x k, then dot products
	logic signed [2*UW-1:0] ip_t1 [6];
	logic signed [UW-1:0]   j_t1 [3], k_t1 [3], j_t2 [3], k_t2 [3], j_t3 [3], k_t3 [3];
	logic signed [DW2-1:0]  id_t2 [3];
	logic signed [IW-1:0]   i_t3 [3];
	logic signed [PW-1:0]   dp_t4 [9];
	logic signed [AW-1:0]   acc_t5 [3];
	logic signed [TW-1:0]   sh_t6 [3];
	logic deg_t1, deg_t2, deg_t3, deg_t4, deg_t5, deg_t6;
	logic signed [IW-1:0]   ic [3];
	logic signed [TW-1:0]   shc [3];
	logic signed [CW-1:0]   satc [3];

	always_comb begin
		logic signed [DW2-1:0] tq;
		logic signed [AW-1:0]  ta;
		for (int c = 0; c < 3; c++) begin
			tq    = id_t2[c] >>> UFB;
			ic[c] = $signed(tq[IW-1:0]
				+ IW'(id_t2[c] < 0 && id_t2[c][UFB-1:0] != '0));
			ta     = acc_t5[c] >>> UFB;
			shc[c] = $signed(ta[TW-1:0]
				+ TW'(acc_t5[c] < 0 && acc_t5[c][UFB-1:0] != '0));
			if (&sh_t6[c][TW-1:CW-1] || ~|sh_t6[c][TW-1:CW-1]) begin
				satc[c] = sh_t6[c][CW-1:0];
			end else if (sh_t6[c][TW-1]) begin
				satc[c] = {1'b1, {(CW-1){1'b0}}};
			end else begin
				satc[c] = {1'b0, {(CW-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ip_t1[0] <= jj[1] * kk[2];
			ip_t1[1] <= jj[2] * kk[1];
			ip_t1[2] <= jj[2] * kk[0];
			ip_t1[3] <= jj[0] * kk[2];
			ip_t1[4] <= jj[0] * kk[1];
			ip_t1[5] <= jj[1] * kk[0];
			j_t1   <= jj;
			k_t1   <= kk;
			deg_t1 <= k_z || j_z;

			for (int c = 0; c < 3; c++) begin
				id_t2[c] <= DW2'(ip_t1[2*c]) - DW2'(ip_t1[2*c+1]);
			end
			j_t2   <= j_t1;
			k_t2   <= k_t1;
			deg_t2 <= deg_t1;

			i_t3   <= ic;
			j_t3   <= j_t2;
			k_t3   <= k_t2;
			deg_t3 <= deg_t2;

			for (int c = 0; c < 3; c++) begin
				dp_t4[c]   <= i_t3[c] * ud_q[UNIT_LAT+2][c];
				dp_t4[3+c] <= j_t3[c] * ud_q[UNIT_LAT+2][c];
				dp_t4[6+c] <= k_t3[c] * ud_q[UNIT_LAT+2][c];
			end
			deg_t4 <= deg_t3;

			for (int a = 0; a < 3; a++) begin
				acc_t5[a] <= AW'(dp_t4[3*a]) + AW'(dp_t4[3*a+1]) + AW'(dp_t4[3*a+2]);
			end
			deg_t5 <= deg_t4;

			sh_t6  <= shc;
			deg_t6 <= deg_t5;

			result.orb_x      <= deg_t6 ? '0 : satc[0];
			result.orb_y      <= deg_t6 ? '0 : satc[1];
			result.orb_z      <= deg_t6 ? '0 : satc[2];
			result.degenerate <= deg_t6;
		end
	end

	assign result_valid = v_t7;

`ifndef SYNTHESIS
	a_units_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		k_v == j_v)
		else $error("unit pipelines out of step");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |->
			result.orb_x == '0 && result.orb_y == '0 && result.orb_z == '0)
		else $error("degenerate result not zero");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> v_t1 == $past(v_t1) && v_s3 == $past(v_s3))
		else $error("pipeline moved during stall");
`endif

endmodule

// ----- tb/inertial_to_orbital_frame_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inertial_to_orbital_frame_top_tb
// Drives position, velocity and vector items into the frame rotation with
// random gaps and output stalls, predicts each result in fixed point and
// compares every field in order.
// ----------------------------------------------------------------------------
module inertial_to_orbital_frame_top_tb;
	import iof_pkg::*;

	localparam int N_RANDOM   = 1700;
	localparam int WDOG_LIMIT = 20000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_ready;
	in_t   item = '0;
	logic  result_valid;
	logic  result_ready = 1'b0;
	out_t  result;

	int    n_errors = 0;
	int    idle_cycles = 0;
	bit    inputs_done = 1'b0;

	inertial_to_orbital_frame_top DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	always #10 clk = ~clk;

	function automatic void report(input string what, input longint got, input longint want);
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		n_errors++;
	endfunction

	// ---- fixed point frame predictor ----
	function automatic logic [63:0] mag_of(input logic signed [255:0] x);
		logic [255:0] m;
		m = x[255] ? -x : x;
		return m[63:0];
	endfunction

	function automatic logic signed [255:0] trunc_shr(input logic signed [255:0] x,
			input int s);
		logic [255:0] m;
		m = x[255] ? -x : x;
		m = m >> s;
		return x[255] ? -$signed(m) : $signed(m);
	endfunction

	function automatic int bit_len(input logic signed [255:0] x);
		logic [255:0] m;
		int n;
		m = x[255] ? -x : x;
		n = 0;
		while (m != 0) begin
			n++;
			m = m >> 1;
		end
		return n;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] m);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > m) b = b >> 2;
		while (b != 0) begin
			if (m >= res + b) begin
				m = m - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic bit unit_dir(input logic signed [255:0] d[3],
			output logic signed [255:0] un[3]);
		int L, b;
		logic signed [255:0] n[3];
		logic [63:0] m2, s, q;
		logic [127:0] num;
		L = 0;
		for (int c = 0; c < 3; c++) begin
			b = bit_len(d[c]);
			if (b > L) L = b;
		end
		if (L == 0) return 0;
		m2 = 0;
		for (int c = 0; c < 3; c++) begin
			n[c] = (L > NB) ? trunc_shr(d[c], L - NB) : (d[c] <<< (NB - L));
			m2 += mag_of(n[c]) * mag_of(n[c]);
		end
		s = int_sqrt(m2);
		if (s == 0) return 0;
		for (int c = 0; c < 3; c++) begin
			num = {64'd0, mag_of(n[c])} << NB;
			q = 64'(num / s);
			if (UFB >= NB) q = q << (UFB - NB);
			else q = q >> (NB - UFB);
			un[c] = n[c][255] ? -$signed({192'd0, q}) : $signed({192'd0, q});
		end
		return 1;
	endfunction

	function automatic out_t rotate_to_orbit(input in_t it);
		logic signed [255:0] r[3], v[3], u[3], x[3], k[3], j[3], ia[3], acc;
		logic signed [255:0] lim;
		out_t o;
		r[0] = it.pos_x; r[1] = it.pos_y; r[2] = it.pos_z;
		v[0] = it.vel_x; v[1] = it.vel_y; v[2] = it.vel_z;
		u[0] = it.vec_x; u[1] = it.vec_y; u[2] = it.vec_z;
		x[0] = r[1] * v[2] - r[2] * v[1];
		x[1] = r[2] * v[0] - r[0] * v[2];
		x[2] = r[0] * v[1] - r[1] * v[0];
		o = '0;
		if (!unit_dir(r, k) || !unit_dir(x, j)) begin
			o.degenerate = 1'b1;
			return o;
		end
		ia[0] = trunc_shr(j[1] * k[2] - j[2] * k[1], UFB);
		ia[1] = trunc_shr(j[2] * k[0] - j[0] * k[2], UFB);
		ia[2] = trunc_shr(j[0] * k[1] - j[1] * k[0], UFB);
		lim = 256'sd1 <<< (CW - 1);
		for (int a = 0; a < 3; a++) begin
			case (a)
				0: acc = ia[0] * u[0] + ia[1] * u[1] + ia[2] * u[2];
				1: acc = j[0] * u[0] + j[1] * u[1] + j[2] * u[2];
				default: acc = k[0] * u[0] + k[1] * u[1] + k[2] * u[2];
			endcase
			acc = trunc_shr(acc, UFB);
			if (acc >= lim) acc = lim - 1;
			if (acc < -lim) acc = -lim;
			case (a)
				0: o.orb_x = acc[CW-1:0];
				1: o.orb_y = acc[CW-1:0];
				default: o.orb_z = acc[CW-1:0];
			endcase
		end
		return o;
	endfunction

	class frame_scoreboard;
		out_t pending[$];

		function void note_item(input in_t it);
			pending.push_back(rotate_to_orbit(it));
		endfunction

		function void check_result(input out_t got);
			out_t want;
			if (pending.size() == 0) begin
				report("unexpected result, degenerate", longint'(got.degenerate), 0);
				return;
			end
			want = pending.pop_front();
			if (got.orb_x !== want.orb_x)
				report("orb_x", longint'(got.orb_x), longint'(want.orb_x));
			if (got.orb_y !== want.orb_y)
				report("orb_y", longint'(got.orb_y), longint'(want.orb_y));
			if (got.orb_z !== want.orb_z)
				report("orb_z", longint'(got.orb_z), longint'(want.orb_z));
			if (got.degenerate !== want.degenerate)
				report("degenerate", longint'(got.degenerate), longint'(want.degenerate));
		endfunction
	endclass

	frame_scoreboard sb = new();

	// ---- stimulus ----
	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $signed($urandom_range(0, 20)) - 10;
			1: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
			2: return $signed($urandom) >>> $urandom_range(0, 30);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input in_t it);
		int gap;
		gap = $urandom_range(0, 18);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk iff item_ready);
	endtask

	task automatic send_item_burst(input in_t it);
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk iff item_ready);
	endtask

	function automatic in_t mk(input longint px, py, pz, vx, vy, vz, ux, uy, uz);
		in_t it;
		it.pos_x = CW'(px); it.pos_y = CW'(py); it.pos_z = CW'(pz);
		it.vel_x = CW'(vx); it.vel_y = CW'(vy); it.vel_z = CW'(vz);
		it.vec_x = CW'(ux); it.vec_y = CW'(uy); it.vec_z = CW'(uz);
		return it;
	endfunction

	task automatic run_stimulus();
		in_t it;
		longint mx, mn;
		mx = 64'sd2147483647;
		mn = -64'sd2147483648;
		send_item(mk(0, 0, 0, 5, 6, 7, 1, 2, 3));
		send_item(mk(1, 2, 3, 0, 0, 0, 4, 5, 6));
		send_item(mk(2, 4, 6, 1, 2, 3, 7, 8, 9));
		send_item(mk(mn, 0, 0, mn, 0, 0, mx, mx, mx));
		send_item(mk(7000, 0, 0, 0, 7500, 0, 100, 200, 300));
		send_item(mk(mx, mx, mx, mn, mx, mn, mx, mx, mx));
		send_item(mk(mn, mn, mn, mx, mn, mx, mn, mn, mn));
		send_item(mk(mn, mx, mn, mx, mn, mn, mx, mn, mx));
		send_item(mk(1, 0, 0, 0, 1, 0, mx, mn, mx));
		send_item(mk(0, 0, -1, -1, 0, 0, mn, mn, mn));
		send_item(mk(mx, 1, 0, 0, 1, mx, mx, mx, mn));
		send_item(mk(-1, -1, -1, 1, -1, 0, -1, -1, -1));
		send_item(mk(mx, -3, 5, 7, mn, -9, mx, -1, mn));
		for (int n = 0; n < N_RANDOM; n++) begin
			for (int f = 0; f < 9; f++) it[f*CW +: CW] = rand_coord();
			if ($urandom_range(0, 30) == 0) begin
				it.vel_x = it.pos_x; it.vel_y = it.pos_y; it.vel_z = it.pos_z;
			end
			if ($urandom_range(0, 60) == 0) begin
				it.pos_x = 0; it.pos_y = 0; it.pos_z = 0;
			end
			if ($urandom_range(0, 4) == 0) send_item_burst(it);
			else send_item(it);
		end
		item_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (item_valid && item_ready) sb.note_item(item);
		if (result_valid && result_ready) sb.check_result(result);
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
				(sb.pending.size() == 0 && !item_valid))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		int wait_n;
		forever begin
			@(posedge clk);
			if (!result_ready) begin
				wait_n = $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
				repeat (wait_n) @(posedge clk);
				result_ready <= 1'b1;
			end else if (result_valid) begin
				result_ready <= 1'b0;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_stimulus();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		inputs_done = 1'b1;
	end

	initial begin
		while (!inputs_done && idle_cycles < WDOG_LIMIT) @(posedge clk);
		if (inputs_done && n_errors == 0 && sb.pending.size() == 0)
			$display("inertial_to_orbital_frame_top: match");
		else
			$display("inertial_to_orbital_frame_top: mismatch");
		$finish;
	end

endmodule

// ----- inertial_to_orbital_frame_top.f -----
rtl/core/iof_pkg.sv
rtl/core/iof_unit.sv
rtl/core/inertial_to_orbital_frame_top.sv
tb/inertial_to_orbital_frame_top_tb.sv
